// ----- rtl/core/wgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wgt_pkg
// Shared sizes, codes and types for the wind gust and trend tracker.
// -----------------------------------------------------------------------------
package wgt_pkg;

  localparam int unsigned GUST_DEPTH  = 10;
  localparam int unsigned TREND_DEPTH = 30;
  localparam int unsigned HALF        = TREND_DEPTH / 2;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // the sample chain must cover both windows
  localparam int unsigned CHAIN_LEN = (GUST_DEPTH > TREND_DEPTH) ? GUST_DEPTH : TREND_DEPTH;
  localparam int unsigned IDX_W     = $clog2(CHAIN_LEN);

  localparam int unsigned GSUM_W = $clog2(GUST_DEPTH * 65535 + 1);
  localparam int unsigned HSUM_W = $clog2(HALF * 65535 + 1);
  localparam int unsigned GCMP_W = $clog2(3 * GUST_DEPTH * 65535 + 1);
  localparam int unsigned TCMP_W = $clog2(HALF * 65535 + HALF * 1023 + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GUST_MIN_AVG = 1'b0,
    REG_TREND_MARGIN = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } wgt_state_e;

  typedef struct packed {
    logic             clr;  // start of a new sample
    logic             en;   // tail holds a valid chain entry
    logic [IDX_W-1:0] idx;  // age of the tail entry, 0 = newest
  } acc_ctrl_t;

endpackage : wgt_pkg
`default_nettype wire

// ----- rtl/core/wgt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wgt_cell
// One stage of the sample chain: holds a speed and passes it on when shifted.
// -----------------------------------------------------------------------------
module wgt_cell (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [wgt_pkg::SPEED_W-1:0] d_i,
  output logic [wgt_pkg::SPEED_W-1:0] q_o
);
  import wgt_pkg::*;

  logic [SPEED_W-1:0] speed_q;
  logic [SPEED_W-1:0] speed_d;

  assign speed_d = shift_i ? d_i : speed_q;

  // zero start is shifted in by the top level after reset
  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
  end

  assign q_o = speed_q;

endmodule : wgt_cell
`default_nettype wire

// ----- rtl/core/wgt_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wgt_accum
// Collects max and sums from the chain tail and forms the gust/trend flags.
// -----------------------------------------------------------------------------
module wgt_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wgt_pkg::acc_ctrl_t          ctrl_i,
  input  logic [wgt_pkg::SPEED_W-1:0] tail_i,
  input  logic [wgt_pkg::CFG_W-1:0]   min_avg_i,
  input  logic [wgt_pkg::CFG_W-1:0]   margin_i,
  output logic [wgt_pkg::SPEED_W-1:0] gust_o,
  output logic                        gusting_o,
  output logic                        increasing_o
);
  import wgt_pkg::*;

  logic [SPEED_W-1:0] max_q, max_d;
  logic [GSUM_W-1:0]  gsum_q, gsum_d;
  logic [HSUM_W-1:0]  newer_q, newer_d;
  logic [HSUM_W-1:0]  older_q, older_d;
  logic [31:0]        age;

  logic [GCMP_W-1:0]  gthr, glhs, grhs;
  logic [TCMP_W-1:0]  trhs;

  assign age = 32'(ctrl_i.idx);

  always_comb begin
    max_d   = max_q;
    gsum_d  = gsum_q;
    newer_d = newer_q;
    older_d = older_q;
    if (ctrl_i.clr) begin
      max_d   = '0;
      gsum_d  = '0;
      newer_d = '0;
      older_d = '0;
    end else if (ctrl_i.en) begin
      if (age < GUST_DEPTH) begin
        gsum_d = gsum_q + GSUM_W'(tail_i);
        if (tail_i > max_q) max_d = tail_i;
      end
      if (age < HALF) begin
        newer_d = newer_q + HSUM_W'(tail_i);
      end else if (age < 2 * HALF) begin
        older_d = older_q + HSUM_W'(tail_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      gsum_q  <= '0;
      newer_q <= '0;
      older_q <= '0;
    end else begin
      max_q   <= max_d;
      gsum_q  <= gsum_d;
      newer_q <= newer_d;
      older_q <= older_d;
    end
  end

  // gust > 1.5 * average  <=>  2*N*gust > 3*sum
  assign gthr = GCMP_W'(GUST_DEPTH) * GCMP_W'(min_avg_i);
  assign glhs = GCMP_W'(2 * GUST_DEPTH) * GCMP_W'(max_q);
  assign grhs = GCMP_W'(3) * GCMP_W'(gsum_q);
  assign trhs = TCMP_W'(older_q) + TCMP_W'(HALF) * TCMP_W'(margin_i);

  assign gust_o       = max_q;
  assign gusting_o    = (GCMP_W'(gsum_q) > gthr) && (glhs > grhs);
  assign increasing_o = TCMP_W'(newer_q) > trhs;

endmodule : wgt_accum
`default_nettype wire

// ----- rtl/core/wind_gust_trend_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wind_gust_trend_tracker
// Gust maximum and speed trend over a chain of recent wind-speed samples.
// -----------------------------------------------------------------------------
// Each accepted speed sample is shifted into a chain of CHAIN_LEN cells
// (newest first). The chain is then rotated once around, one cell per cycle,
// past a single accumulator that builds the gust maximum, the gust window sum
// and the two trend half sums; the flags, formed combinationally from the
// accumulator, are then loaded into the result register once the previous
// result has been taken or is being taken. A new sample is taken once the
// result register is loaded, even while that result is still pending at the
// output. Reset clears the chain to zero speeds, one cell per cycle, during
// which no sample is accepted; configuration writes are taken at any time.
// -----------------------------------------------------------------------------
module wind_gust_trend_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wgt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wgt_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          speed_valid_i,
  output logic                          speed_ready_o,
  input  logic [wgt_pkg::SPEED_W-1:0]   speed_raw_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [wgt_pkg::SPEED_W-1:0]   gust_speed_o,
  output logic                          is_gusting_o,
  output logic                          is_increasing_o
);
  import wgt_pkg::*;

  wgt_state_e         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               clr_busy_q, clr_busy_d;
  logic [CFG_W-1:0]   min_avg_q, margin_q;

  logic [SPEED_W-1:0] chain [CHAIN_LEN];
  logic [SPEED_W-1:0] head;
  logic               shift;
  logic               accept;
  logic               load_out;
  acc_ctrl_t          actrl;

  logic [SPEED_W-1:0] gust;
  logic               gusting, increasing;

  logic               out_valid_q;
  logic [SPEED_W-1:0] gust_q;
  logic               gusting_q, increasing_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_avg_q <= CFG_W'(5);
      margin_q  <= CFG_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GUST_MIN_AVG: min_avg_q <= cfg_data_i;
        REG_TREND_MARGIN: margin_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = speed_valid_i && speed_ready_o;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    clr_busy_d = clr_busy_q;
    shift      = 1'b0;
    head       = chain[CHAIN_LEN-1];
    load_out   = 1'b0;
    speed_ready_o = 1'b0;
    actrl.clr  = 1'b0;
    actrl.en   = 1'b0;
    actrl.idx  = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (clr_busy_q) begin
          // shift zeros through the whole chain after reset
          shift = 1'b1;
          head  = '0;
          if (idx_q == '0) clr_busy_d = 1'b0;
          else idx_d = idx_q - IDX_W'(1);
        end else begin
          speed_ready_o = 1'b1;
          if (speed_valid_i) begin
            shift     = 1'b1;
            head      = speed_raw_i;
            actrl.clr = 1'b1;
            idx_d     = IDX_W'(CHAIN_LEN - 1);
            state_d   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // rotate: tail feeds the accumulator and wraps to the head
        shift    = 1'b1;
        actrl.en = 1'b1;
        if (idx_q == '0) state_d = ST_FIN;
        else idx_d = idx_q - IDX_W'(1);
      end
      ST_FIN: begin
        if (!out_valid_q || result_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= IDX_W'(CHAIN_LEN - 1);
      clr_busy_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
    if (i == 0) begin : g_head
      wgt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (head),
        .q_o     (chain[i])
      );
    end else begin : g_body
      wgt_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (chain[i-1]),
        .q_o     (chain[i])
      );
    end
  end

  wgt_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (actrl),
    .tail_i       (chain[CHAIN_LEN-1]),
    .min_avg_i    (min_avg_q),
    .margin_i     (margin_q),
    .gust_o       (gust),
    .gusting_o    (gusting),
    .increasing_o (increasing)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      gust_q       <= gust;
      gusting_q    <= gusting;
      increasing_q <= increasing;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign gust_speed_o    = gust_q;
  assign is_gusting_o    = gusting_q;
  assign is_increasing_o = increasing_q;

endmodule : wind_gust_trend_tracker
`default_nettype wire

// ----- rtl/core/wgt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wgt_checker
// Port-level checks for the wind gust and trend tracker, bound to the top.
// -----------------------------------------------------------------------------
module wgt_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        speed_valid_i,
  input  logic                        speed_ready_o,
  input  logic                        result_valid_o,
  input  logic                        result_ready_i,
  input  logic [wgt_pkg::SPEED_W-1:0] gust_speed_o,
  input  logic                        is_gusting_o,
  input  logic                        is_increasing_o
);
  import wgt_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(gust_speed_o)
      && $stable(is_gusting_o) && $stable(is_increasing_o))
    else $error("result changed while stalled");

  // one sample at a time: the walk follows each accepted transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_valid_i && speed_ready_o |=> !speed_ready_o)
    else $error("sample accepted during a walk");

  // a gust needs a nonzero maximum
  a_gust_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_gusting_o |-> gust_speed_o != '0)
    else $error("gusting flagged with zero gust");

  // no result appears in the cycle right after a sample is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_valid_i && speed_ready_o && !result_valid_o |=> !result_valid_o)
    else $error("result appeared without a walk");

endmodule : wgt_checker

bind wind_gust_trend_tracker wgt_checker u_wgt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .speed_valid_i   (speed_valid_i),
  .speed_ready_o   (speed_ready_o),
  .result_valid_o  (result_valid_o),
  .result_ready_i  (result_ready_i),
  .gust_speed_o    (gust_speed_o),
  .is_gusting_o    (is_gusting_o),
  .is_increasing_o (is_increasing_o)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wind gust and trend tracker.
// -----------------------------------------------------------------------------
// A directed opening runs while the rings are still filling. Shaped random
// wind follows: calm air with spikes, rising and falling ramps, steady flow,
// single-bit patterns and raw noise. The phases step through pairs of
// thresholds, the extremes among them. Every accepted sample is run through
// an in-bench gust/trend predictor. Each result transaction is checked
// against the oldest prediction. Both handshakes idle at random. One phase
// has no idling at all. In another, the output is held off long enough to
// stall the input.
// -----------------------------------------------------------------------------

typedef struct packed {
  logic [wgt_pkg::SPEED_W-1:0] gust_speed;
  logic                        is_gusting;
  logic                        is_increasing;
} gust_result_t;

class gust_trend_scoreboard;
  logic [wgt_pkg::SPEED_W-1:0] gust_ring [wgt_pkg::GUST_DEPTH];
  logic [wgt_pkg::SPEED_W-1:0] trend_ring [wgt_pkg::TREND_DEPTH];
  int unsigned                 gust_slot;
  int unsigned                 trend_slot;
  logic [wgt_pkg::CFG_W-1:0]   min_average;
  logic [wgt_pkg::CFG_W-1:0]   margin;
  gust_result_t                predicted_q [$];
  int unsigned                 fails;

  function new();
    foreach (gust_ring[i]) gust_ring[i] = '0;
    foreach (trend_ring[i]) trend_ring[i] = '0;
    gust_slot   = 0;
    trend_slot  = 0;
    min_average = 10'd5;
    margin      = 10'd5;
    fails       = 0;
  endfunction

  function void write_reg(wgt_pkg::cfg_reg_e idx, logic [wgt_pkg::CFG_W-1:0] value);
    case (idx)
      wgt_pkg::REG_GUST_MIN_AVG: min_average = value;
      wgt_pkg::REG_TREND_MARGIN: margin = value;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return predicted_q.size();
  endfunction

  // store the sample first: both flags see the new sample
  function void note_sample(logic [wgt_pkg::SPEED_W-1:0] speed);
    longint unsigned window_sum;
    longint unsigned newer_sum;
    longint unsigned older_sum;
    int unsigned     slot;
    gust_result_t    res;

    gust_ring[gust_slot] = speed;
    gust_slot = (gust_slot + 1) % wgt_pkg::GUST_DEPTH;
    trend_ring[trend_slot] = speed;
    trend_slot = (trend_slot + 1) % wgt_pkg::TREND_DEPTH;

    window_sum = 0;
    res.gust_speed = '0;
    foreach (gust_ring[i]) begin
      if (gust_ring[i] > res.gust_speed) res.gust_speed = gust_ring[i];
      window_sum += gust_ring[i];
    end
    res.is_gusting =
        (window_sum > longint'(wgt_pkg::GUST_DEPTH) * min_average) &&
        (longint'(2 * wgt_pkg::GUST_DEPTH) * res.gust_speed > 3 * window_sum);

    // newer half: ages 1..HALF back from the write slot, older half right behind
    newer_sum = 0;
    older_sum = 0;
    for (int k = 1; k <= 2 * wgt_pkg::HALF; k++) begin
      slot = (trend_slot + wgt_pkg::TREND_DEPTH - k) % wgt_pkg::TREND_DEPTH;
      if (k <= wgt_pkg::HALF) newer_sum += trend_ring[slot];
      else older_sum += trend_ring[slot];
    end
    res.is_increasing = newer_sum > older_sum + longint'(wgt_pkg::HALF) * margin;

    predicted_q.push_back(res);
  endfunction

  function void check_result(logic [wgt_pkg::SPEED_W-1:0] gust, logic gusting,
                             logic increasing);
    gust_result_t exp_res;
    if (predicted_q.size() == 0) begin
      $error("result transaction with no sample pending: gust_speed %0d", gust);
      fails++;
      return;
    end
    exp_res = predicted_q.pop_front();
    if (gust !== exp_res.gust_speed) begin
      $error("gust_speed: expected %0d, actual %0d", exp_res.gust_speed, gust);
      fails++;
    end
    if (gusting !== exp_res.is_gusting) begin
      $error("is_gusting: expected %0d, actual %0d", exp_res.is_gusting, gusting);
      fails++;
    end
    if (increasing !== exp_res.is_increasing) begin
      $error("is_increasing: expected %0d, actual %0d", exp_res.is_increasing, increasing);
      fails++;
    end
  endfunction
endclass

module testbench;
  import wgt_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 140;

  typedef enum int {
    WIND_NOISE,
    WIND_CALM_SPIKES,
    WIND_RISE,
    WIND_FALL,
    WIND_STEADY,
    WIND_BITS
  } wind_pattern_e;

  // zeros, full scale, a spike leaving the window, a small spike, steep ramp
  localparam logic [SPEED_W-1:0] OPENING_SPEEDS [24] = '{
    16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd50, 16'd50, 16'd50, 16'd50, 16'd50, 16'd500, 16'd1000,
    16'd2000, 16'd4000, 16'd8000, 16'd16000, 16'd32768, 16'd65535
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               speed_valid_i;
  logic               speed_ready_o;
  logic [SPEED_W-1:0] speed_raw_i;
  logic               result_valid_o;
  logic               result_ready_i;
  logic [SPEED_W-1:0] gust_speed_o;
  logic               is_gusting_o;
  logic               is_increasing_o;

  gust_trend_scoreboard sb;

  bit            no_idle;
  bit            hold_req;
  int unsigned   quiet_cycles;
  wind_pattern_e pattern;
  int            pattern_left;
  int            wind_level;

  wind_gust_trend_tracker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .speed_valid_i  (speed_valid_i),
    .speed_ready_o  (speed_ready_o),
    .speed_raw_i    (speed_raw_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .gust_speed_o   (gust_speed_o),
    .is_gusting_o   (is_gusting_o),
    .is_increasing_o(is_increasing_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clamp_speed(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic logic [SPEED_W-1:0] next_wind();
    int v;
    if (pattern_left == 0) begin
      pattern      = wind_pattern_e'($urandom_range(WIND_NOISE, WIND_BITS));
      pattern_left = $urandom_range(10, 40);
      wind_level   = $urandom_range(0, 4000);
    end
    pattern_left--;
    case (pattern)
      WIND_CALM_SPIKES: begin
        v = wind_level + $urandom_range(0, 40);
        if ($urandom_range(0, 7) == 0) v = v * $urandom_range(2, 5) + $urandom_range(0, 20);
      end
      WIND_RISE: begin
        wind_level = clamp_speed(wind_level + $urandom_range(0, 2500));
        v = wind_level;
      end
      WIND_FALL: begin
        wind_level = clamp_speed(wind_level + 20000 - $urandom_range(0, 2500));
        wind_level = clamp_speed(wind_level - 20000 - $urandom_range(0, 2500));
        v = wind_level;
      end
      WIND_STEADY: v = wind_level + $urandom_range(0, 40) - 20;
      WIND_BITS: begin
        case ($urandom_range(0, 3))
          0: v = 1 << $urandom_range(0, 15);
          1: v = 16'hFFFF ^ (1 << $urandom_range(0, 15));
          2: v = 16'hFFFF;
          default: v = 0;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    return SPEED_W'(clamp_speed(v));
  endfunction

  // valid stays up across back-to-back transactions; dropped only to idle
  task automatic send_sample(logic [SPEED_W-1:0] speed);
    @(negedge clk_i);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 20) begin
        speed_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    speed_valid_i = 1'b1;
    speed_raw_i   = speed;
    do @(posedge clk_i); while (!speed_ready_o);
    sb.note_sample(speed);
  endtask

  task automatic drain();
    @(negedge clk_i);
    speed_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] min_avg, logic [CFG_W-1:0] trend_margin);
    drain();
    write_reg(REG_GUST_MIN_AVG, min_avg);
    write_reg(REG_TREND_MARGIN, trend_margin);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_sample(next_wind());
  endtask

  // output side: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        result_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      result_ready_i = no_idle || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i)
      sb.check_result(gust_speed_o, is_gusting_o, is_increasing_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (speed_valid_i && speed_ready_o) || (result_valid_o && result_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[wind_gust_trend_tracker] ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb             = new();
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    pattern        = WIND_NOISE;
    pattern_left   = 0;
    wind_level     = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_GUST_MIN_AVG;
    cfg_data_i     = '0;
    speed_valid_i  = 1'b0;
    speed_raw_i    = '0;
    result_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset thresholds; rings still filling during the opening
    foreach (OPENING_SPEEDS[i]) send_sample(OPENING_SPEEDS[i]);
    send_random(PHASE_ITEMS);

    configure(10'd0, 10'd0);
    send_random(PHASE_ITEMS);

    configure(10'd1023, 10'd1023);
    no_idle = 1'b1;
    send_random(PHASE_ITEMS);
    no_idle = 1'b0;

    configure(10'd0, 10'd1023);
    send_random(PHASE_ITEMS);

    configure(10'd1023, 10'd0);
    send_random(PHASE_ITEMS);

    configure(CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom_range(0, 1023)));
    hold_req = 1'b1;
    send_random(PHASE_ITEMS);

    configure(10'd5, 10'd5);
    send_random(PHASE_ITEMS);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("[wind_gust_trend_tracker] OK");
    end else begin
      $display("[wind_gust_trend_tracker] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/wgt_pkg.sv
rtl/core/wgt_cell.sv
rtl/core/wgt_accum.sv
rtl/core/wind_gust_trend_tracker.sv
rtl/core/wgt_checker.sv
bench/testbench.sv
